// ===== rtl/rpk_pkg.sv =====
// ----------------------------------------------------------------------------
// rpk_pkg
// Shared types for the rectilinear polygon kernel test: port payloads,
// the bound selector and the task record passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package rpk_pkg;

  // windows examined for one vertex: one regular plus three for ring closure
  localparam int NumWin = 4;

  // one vertex on the input side
  typedef struct packed {
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic               last_vertex;
  } rpk_vert_t;

  // one result on the output side
  typedef struct packed {
    logic kernel_exists;
    logic too_few;
  } rpk_result_t;

  // which bound a dent edge tightens
  typedef enum logic [1:0] {
    BND_LOW_X,
    BND_HIGH_X,
    BND_LOW_Y,
    BND_HIGH_Y
  } rpk_bound_e;

  // classification of one window
  typedef struct packed {
    logic       dent;
    rpk_bound_e kind;
  } rpk_win_t;

  // control part of one task in the front-to-back queue
  typedef struct packed {
    rpk_win_t [NumWin-1:0] win;
    logic                  last;
    logic                  too_few;
  } rpk_task_t;

endpackage

`default_nettype wire

// ===== rtl/rpk_fifo.sv =====
// ----------------------------------------------------------------------------
// rpk_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
`default_nettype none

module rpk_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpk_front.sv =====
// ----------------------------------------------------------------------------
// rpk_front
// Vertex intake: keeps the first and most recent three vertices, classifies
// the window ending at each new vertex and, on the last vertex, the three
// ring closure windows.
// ----------------------------------------------------------------------------
`default_nettype none

module rpk_front import rpk_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire rpk_vert_t                  vert_i,
  input  wire logic                       full_i,
  output logic                            task_push_o,
  output rpk_task_t                       task_o,
  output logic [NumWin*COORD_BITS-1:0]    vals_o
);

  localparam int CB   = COORD_BITS;
  localparam int VW   = 2 * CB;
  localparam int ExtW = (CB > 16) ? CB : 16;

  logic [VW-1:0] first_q  [3];
  logic [VW-1:0] recent_q [3];
  logic [2:0]    cnt_q, cnt_d;

  logic            fire;
  logic [ExtW-1:0] xe, ye;
  logic [VW-1:0]   v;
  logic            have3;
  logic            closing;
  rpk_task_t       tsk;
  logic            any_dent;

  // window classification of middle edge b-c
  function automatic rpk_win_t win_class(input logic [VW-1:0] a, input logic [VW-1:0] b,
                                         input logic [VW-1:0] c, input logic [VW-1:0] d);
    logic signed [CB-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    rpk_win_t r;
    ax = $signed(a[VW-1:CB]);
    ay = $signed(a[CB-1:0]);
    bx = $signed(b[VW-1:CB]);
    by = $signed(b[CB-1:0]);
    cx = $signed(c[VW-1:CB]);
    cy = $signed(c[CB-1:0]);
    dx = $signed(d[VW-1:CB]);
    dy = $signed(d[CB-1:0]);
    if (bx == cx) begin
      r.dent = ((ax < bx) != (cx < dx));
      r.kind = (by < cy) ? BND_HIGH_X : BND_LOW_X;
    end else begin
      r.dent = ((ay < by) != (cy < dy));
      r.kind = (bx < cx) ? BND_LOW_Y : BND_HIGH_Y;
    end
    return r;
  endfunction

  // coordinate that a dent edge b-c contributes
  function automatic logic [CB-1:0] win_val(input logic [VW-1:0] b, input logic [VW-1:0] c);
    return (b[VW-1:CB] == c[VW-1:CB]) ? b[VW-1:CB] : b[CB-1:0];
  endfunction

  assign fire = push_i && !full_i;

  // coordinates as two's complement of the configured width
  assign xe = ExtW'($unsigned(vert_i.vert_x));
  assign ye = ExtW'($unsigned(vert_i.vert_y));
  assign v  = {xe[CB-1:0], ye[CB-1:0]};

  assign have3   = (cnt_q >= 3'd3);
  assign closing = vert_i.last_vertex && have3;

  // classify the regular window and the closure windows
  always_comb begin
    tsk = '0;
    tsk.win[0]  = win_class(recent_q[0], recent_q[1], recent_q[2], v);
    tsk.win[1]  = win_class(recent_q[1], recent_q[2], v, first_q[0]);
    tsk.win[2]  = win_class(recent_q[2], v, first_q[0], first_q[1]);
    tsk.win[3]  = win_class(v, first_q[0], first_q[1], first_q[2]);
    tsk.win[0].dent = tsk.win[0].dent && have3;
    tsk.win[1].dent = tsk.win[1].dent && closing;
    tsk.win[2].dent = tsk.win[2].dent && closing;
    tsk.win[3].dent = tsk.win[3].dent && closing;
    tsk.last    = vert_i.last_vertex;
    tsk.too_few = vert_i.last_vertex && !have3;
  end

  assign any_dent = tsk.win[0].dent || tsk.win[1].dent || tsk.win[2].dent ||
                    tsk.win[3].dent;

  assign task_o      = tsk;
  assign vals_o      = {win_val(first_q[0], first_q[1]), win_val(v, first_q[0]),
                        win_val(recent_q[2], v), win_val(recent_q[1], recent_q[2])};
  assign task_push_o = push_i && (any_dent || vert_i.last_vertex);

  // vertex count, saturating, cleared after a last vertex
  always_comb begin
    cnt_d = cnt_q;
    if (fire) begin
      if (vert_i.last_vertex) begin
        cnt_d = '0;
      end else if (cnt_q != 3'd7) begin
        cnt_d = cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // vertex buffers, only read once written
  always_ff @(posedge clk_i) begin
    if (fire) begin
      recent_q[0] <= recent_q[1];
      recent_q[1] <= recent_q[2];
      recent_q[2] <= v;
      if (!have3) begin
        first_q[cnt_q[1:0]] <= v;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpk_back.sv =====
// ----------------------------------------------------------------------------
// rpk_back
// Bound keeper: applies the dent updates of each task to the four bounds
// and, at the end of a polygon, forms the result and clears the bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module rpk_back import rpk_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         task_empty_i,
  input  wire rpk_task_t                    task_i,
  input  wire logic [NumWin*COORD_BITS-1:0] vals_i,
  output logic                              task_pop_o,
  input  wire logic                         res_full_i,
  output logic                              res_push_o,
  output rpk_result_t                       res_o
);

  localparam int CB = COORD_BITS;
  localparam int BW = CB + 1;
  localparam logic signed [BW-1:0] LowSent  = BW'(-(2 ** (CB - 1)) - 1);
  localparam logic signed [BW-1:0] HighSent = BW'(2 ** (CB - 1));

  logic signed [BW-1:0] lx_q, lx_d, hx_q, hx_d, ly_q, ly_d, hy_q, hy_d;
  logic signed [BW-1:0] nlx, nhx, nly, nhy;
  logic signed [BW-1:0] val;
  logic                 fire;

  assign fire       = !task_empty_i && !res_full_i;
  assign task_pop_o = fire;
  assign res_push_o = fire && task_i.last;

  // tighten bounds with every dent window of the task
  always_comb begin
    nlx = lx_q;
    nhx = hx_q;
    nly = ly_q;
    nhy = hy_q;
    val = '0;
    for (int w = 0; w < NumWin; w++) begin
      val = BW'($signed(vals_i[w*CB +: CB]));
      if (task_i.win[w].dent) begin
        if (task_i.win[w].kind == BND_LOW_X && val > nlx) nlx = val;
        if (task_i.win[w].kind == BND_HIGH_X && val < nhx) nhx = val;
        if (task_i.win[w].kind == BND_LOW_Y && val > nly) nly = val;
        if (task_i.win[w].kind == BND_HIGH_Y && val < nhy) nhy = val;
      end
    end
  end

  // result of a finished polygon
  always_comb begin
    res_o.too_few       = task_i.too_few;
    res_o.kernel_exists = !task_i.too_few && (nlx <= nhx) && (nly <= nhy);
  end

  // next bounds: cleared at end of polygon
  always_comb begin
    lx_d = lx_q;
    hx_d = hx_q;
    ly_d = ly_q;
    hy_d = hy_q;
    if (fire) begin
      if (task_i.last) begin
        lx_d = LowSent;
        hx_d = HighSent;
        ly_d = LowSent;
        hy_d = HighSent;
      end else begin
        lx_d = nlx;
        hx_d = nhx;
        ly_d = nly;
        hy_d = nhy;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q <= LowSent;
      hx_q <= HighSent;
      ly_q <= LowSent;
      hy_q <= HighSent;
    end else begin
      lx_q <= lx_d;
      hx_q <= hx_d;
      ly_q <= ly_d;
      hy_q <= hy_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rectilinear_polygon_kernel_test.sv =====
// ----------------------------------------------------------------------------
// rectilinear_polygon_kernel_test
// Streams polygon vertices in and reports, per polygon, whether the kernel
// of the rectilinear polygon is nonempty.
//
//   channel   handshake             payload        transfer rule
//   vertex    push_i / full_o       vert_i         push_i && !full_o
//   result    empty_o / pop_i       result_o       pop_i && !empty_o
//
// One vertex can be taken every cycle while full_o is low. A vertex is
// classified in the cycle it is taken and any task it yields enters a two-entry
// queue; the bound stage retires one task per cycle while the output queue has
// room, and a result passes the task queue and then the result queue on its way
// to the ports. Results wait in a two-entry output queue; when it fills the
// bound stage stops, then the task queue fills and full_o rises. After reset
// all bounds and counts are clear and the first vertex may follow at once.
// ----------------------------------------------------------------------------
`default_nettype none

module rectilinear_polygon_kernel_test import rpk_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire rpk_vert_t   vert_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output rpk_result_t      result_o
);

  localparam int ValW  = NumWin * COORD_BITS;
  localparam int TaskW = $bits(rpk_task_t) + ValW;
  localparam int ResW  = $bits(rpk_result_t);

  logic              task_push, task_pop, task_full, task_empty;
  rpk_task_t         task_in, task_out;
  logic [ValW-1:0]   vals_in, vals_out;
  logic [TaskW-1:0]  task_rd;
  logic              res_push, res_full;
  rpk_result_t       res_in;
  logic [ResW-1:0]   res_rd;

  // intake and classification
  rpk_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .vert_i     (vert_i),
    .full_i     (task_full),
    .task_push_o(task_push),
    .task_o     (task_in),
    .vals_o     (vals_in)
  );

  // queue between front and back
  rpk_fifo #(
    .WIDTH(TaskW),
    .DEPTH(2)
  ) u_task_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (task_push),
    .data_i ({task_in, vals_in}),
    .full_o (task_full),
    .pop_i  (task_pop),
    .data_o (task_rd),
    .empty_o(task_empty)
  );

  assign task_out = rpk_task_t'(task_rd[TaskW-1:ValW]);
  assign vals_out = task_rd[ValW-1:0];

  // bound keeping and result forming
  rpk_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .task_empty_i(task_empty),
    .task_i      (task_out),
    .vals_i      (vals_out),
    .task_pop_o  (task_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue
  rpk_fifo #(
    .WIDTH(ResW),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop_i),
    .data_o (res_rd),
    .empty_o(empty_o)
  );

  assign result_o = rpk_result_t'(res_rd);
  assign full_o   = task_full;

endmodule

`default_nettype wire
